// ----- hw/rtl/imu_tilt_complementary_fusion_unit_assert.svh -----
// Assertion macros for the tilt fusion unit, empty when SYNTH is defined.
`ifndef IMU_TILT_COMPLEMENTARY_FUSION_UNIT_ASSERT_SVH
`define IMU_TILT_COMPLEMENTARY_FUSION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define IMU_TCF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("imu_tcf assertion failed");
`define IMU_TCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu_tcf assertion failed");
`else
`define IMU_TCF_ASSERT(lbl, prop)
`define IMU_TCF_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/imu_tcf_pkg.sv -----
// Shared types, constants and the arctangent table of the tilt fusion unit.
package imu_tcf_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_STEPS      =
        (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
    localparam int ROOT_STEPS        = 16;

    localparam logic [2:0] REG_OFFSET_X     = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z     = 3'd2;
    localparam logic [2:0] REG_BLEND_WEIGHT = 3'd3;
    localparam logic [2:0] REG_RATE_GAIN    = 3'd4;

    localparam logic [16:0] BLEND_WEIGHT_RESET = 17'd1311;
    localparam logic [23:0] RATE_GAIN_RESET    = 24'd25614;
    localparam logic [16:0] WEIGHT_ONE         = 17'd65536;
    localparam logic [1:0]  FIFO_DEPTH         = 2'd2;

    typedef struct packed {
        logic        is_gyro;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_z;
    } sample_t;

    typedef struct packed {
        logic [15:0] offset_x;
        logic [15:0] offset_y;
        logic [15:0] offset_z;
        logic [16:0] blend_weight;
        logic [23:0] rate_gain;
    } cfg_t;

    typedef struct packed {
        logic       full;
        logic [1:0] count;
    } fifo_status_t;

    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/imu_tcf_front.sv -----
// Input side: accepts sample requests, tags them and queues them for the engine.
module imu_tcf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [15:0]                raw_x,
    input  logic [15:0]                raw_y,
    input  logic [15:0]                raw_z,
    output logic                       q_valid,
    output imu_tcf_pkg::sample_t       q_item,
    input  logic                       q_pop,
    output imu_tcf_pkg::fifo_status_t  status
);

    imu_tcf_pkg::sample_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready      = (count_reg != imu_tcf_pkg::FIFO_DEPTH);
    assign push          = in_valid && in_ready;
    assign q_valid       = (count_reg != 2'd0);
    assign pop           = q_pop && q_valid;
    assign q_item        = mem_reg[rd_ptr_reg];
    assign status.full   = !in_ready;
    assign status.count  = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{is_gyro: cmd, raw_x: raw_x, raw_y: raw_y,
                                     raw_z: raw_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/imu_tcf_back.sv -----
// Engine: gyro integration, square root and CORDIC tilt, blend, output register.
module imu_tcf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  imu_tcf_pkg::cfg_t     cfg,
    input  logic                  q_valid,
    input  imu_tcf_pkg::sample_t  q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic signed [7:0]     tilt_x,
    output logic signed [7:0]     tilt_y,
    output logic signed [15:0]    fused_x,
    output logic signed [15:0]    fused_y,
    output logic signed [15:0]    accel_z,
    output logic signed [15:0]    angle_x,
    output logic signed [15:0]    angle_y,
    output logic signed [15:0]    angle_z
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_GMUL, ST_GADD, ST_SQA, ST_SQB, ST_ROOT, ST_ROT, ST_DEG,
        ST_BMUL, ST_BADD, ST_DONE
    } state_t;

    state_t                state_reg;
    imu_tcf_pkg::sample_t  item_reg;
    logic [1:0]            axis_reg;
    logic                  pass_reg;
    logic [4:0]            it_reg;
    logic [31:0]           acc_reg [3];
    logic signed [49:0]    prod_reg;
    logic [31:0]           sq_reg;
    logic [31:0]           res_reg;
    logic [31:0]           bit_reg;
    logic signed [26:0]    x_reg;
    logic signed [26:0]    y_reg;
    logic signed [25:0]    z_reg;
    logic                  zero_reg;
    logic signed [7:0]     tilt_reg [2];
    logic signed [15:0]    fused_reg [2];
    logic                  out_valid_reg;
    logic                  kind_reg;
    logic signed [7:0]     tilt_x_reg, tilt_y_reg;
    logic signed [15:0]    fused_x_reg, fused_y_reg, accel_z_reg;
    logic signed [15:0]    angle_x_reg, angle_y_reg, angle_z_reg;

    logic signed [15:0]    num, sa, sb, raw_sel, off_sel;
    logic signed [16:0]    diff;
    logic signed [41:0]    gprod;
    logic signed [33:0]    ginc;
    logic [31:0]           sq_a, sq_b;
    logic [31:0]           root_trial, n_cur, res_step, n_step;
    logic signed [26:0]    xs, ys;
    logic signed [25:0]    z_abs;
    logic [9:0]            deg_mag;
    logic [7:0]            deg_clamp;
    logic signed [7:0]     deg;
    logic [16:0]           w_eff, w_acc;
    logic signed [49:0]    bprod;
    logic signed [25:0]    tprod;
    logic signed [50:0]    bsum;
    logic signed [18:0]    bfloor;
    logic                  load_out;

    function automatic logic signed [15:0] whole_deg(input logic [31:0] a);
        return a[31:16] + {15'd0, a[31] && (a[15:0] != 16'd0)};
    endfunction

    always_comb
    begin
        num     = pass_reg ? item_reg.raw_y : item_reg.raw_x;
        sa      = pass_reg ? item_reg.raw_x : item_reg.raw_y;
        sb      = item_reg.raw_z;
        unique case (axis_reg)
            2'd0:    begin raw_sel = item_reg.raw_x; off_sel = cfg.offset_x; end
            2'd1:    begin raw_sel = item_reg.raw_y; off_sel = cfg.offset_y; end
            default: begin raw_sel = item_reg.raw_z; off_sel = cfg.offset_z; end
        endcase
        diff    = 17'(raw_sel) - 17'(off_sel);
        gprod   = 42'(diff) * signed'({18'd0, cfg.rate_gain});
        ginc    = 34'((prod_reg[41:0] + 42'sd128) >>> 8);
        sq_a    = 32'(sa * sa);
        sq_b    = 32'(sb * sb);
        n_cur   = sq_reg;
        root_trial = res_reg + bit_reg;
        if (n_cur >= root_trial)
        begin
            n_step   = n_cur - root_trial;
            res_step = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            n_step   = n_cur;
            res_step = res_reg >> 1;
        end
        xs      = x_reg >>> it_reg;
        ys      = y_reg >>> it_reg;
        z_abs   = z_reg[25] ? -z_reg : z_reg;
        deg_mag = z_abs[25:16];
        deg_clamp = (deg_mag > 10'd90) ? 8'd90 : deg_mag[7:0];
        deg     = zero_reg ? 8'sd0 : (z_reg[25] ? -signed'(deg_clamp) : signed'(deg_clamp));
        w_eff   = (cfg.blend_weight > imu_tcf_pkg::WEIGHT_ONE) ?
                  imu_tcf_pkg::WEIGHT_ONE : cfg.blend_weight;
        w_acc   = imu_tcf_pkg::WEIGHT_ONE - w_eff;
        bprod   = 50'(signed'(acc_reg[axis_reg]) * signed'({1'b0, w_acc}));
        tprod   = 26'(tilt_reg[axis_reg[0]] * signed'({1'b0, w_eff}));
        bsum    = 51'(prod_reg) + (51'(tprod) <<< 16);
        bfloor  = 19'(bsum >>> 32);
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg[0]    <= 32'd0;
            acc_reg[1]    <= 32'd0;
            acc_reg[2]    <= 32'd0;
            axis_reg      <= 2'd0;
            pass_reg      <= 1'b0;
            it_reg        <= 5'd0;
            kind_reg      <= 1'b0;
            tilt_x_reg    <= 8'sd0;
            tilt_y_reg    <= 8'sd0;
            fused_x_reg   <= 16'sd0;
            fused_y_reg   <= 16'sd0;
            accel_z_reg   <= 16'sd0;
            angle_x_reg   <= 16'sd0;
            angle_y_reg   <= 16'sd0;
            angle_z_reg   <= 16'sd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        axis_reg  <= 2'd0;
                        pass_reg  <= 1'b0;
                        state_reg <= q_item.is_gyro ? ST_GMUL : ST_SQA;
                    end
                end
                ST_GMUL:
                begin
                    prod_reg  <= 50'(gprod);
                    state_reg <= ST_GADD;
                end
                ST_GADD:
                begin
                    acc_reg[axis_reg] <= acc_reg[axis_reg] + ginc[31:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_GMUL;
                    end
                end
                ST_SQA:
                begin
                    sq_reg    <= sq_a;
                    state_reg <= ST_SQB;
                end
                ST_SQB:
                begin
                    sq_reg    <= sq_reg + sq_b;
                    res_reg   <= 32'd0;
                    bit_reg   <= 32'h4000_0000;
                    it_reg    <= 5'd0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    sq_reg  <= n_step;
                    res_reg <= res_step;
                    bit_reg <= bit_reg >> 2;
                    if (it_reg == 5'(imu_tcf_pkg::ROOT_STEPS - 1))
                    begin
                        x_reg     <= signed'({3'd0, res_step[15:0], 8'd0});
                        y_reg     <= 27'(num) <<< 8;
                        z_reg     <= 26'sd0;
                        zero_reg  <= (res_step[15:0] == 16'd0) && (num == 16'sd0);
                        it_reg    <= 5'd0;
                        state_reg <= ST_ROT;
                    end
                    else
                    begin
                        it_reg <= it_reg + 5'd1;
                    end
                end
                ST_ROT:
                begin
                    if (!y_reg[26])
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + signed'({4'd0, imu_tcf_pkg::atan_q16(it_reg)});
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - signed'({4'd0, imu_tcf_pkg::atan_q16(it_reg)});
                    end
                    if (it_reg == 5'(imu_tcf_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_DEG;
                    end
                    else
                    begin
                        it_reg <= it_reg + 5'd1;
                    end
                end
                ST_DEG:
                begin
                    tilt_reg[pass_reg] <= deg;
                    if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= ST_SQA;
                    end
                    else
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= ST_BMUL;
                    end
                end
                ST_BMUL:
                begin
                    prod_reg  <= bprod;
                    state_reg <= ST_BADD;
                end
                ST_BADD:
                begin
                    fused_reg[axis_reg[0]] <= 16'(bfloor +
                        {18'd0, bsum[50] && (bsum[31:0] != 32'd0)});
                    if (axis_reg == 2'd1)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        axis_reg  <= 2'd1;
                        state_reg <= ST_BMUL;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (load_out)
            begin
                kind_reg    <= item_reg.is_gyro;
                tilt_x_reg  <= item_reg.is_gyro ? 8'sd0 : tilt_reg[0];
                tilt_y_reg  <= item_reg.is_gyro ? 8'sd0 : tilt_reg[1];
                fused_x_reg <= item_reg.is_gyro ? 16'sd0 : fused_reg[0];
                fused_y_reg <= item_reg.is_gyro ? 16'sd0 : fused_reg[1];
                accel_z_reg <= item_reg.is_gyro ? 16'sd0 : item_reg.raw_z;
                angle_x_reg <= whole_deg(acc_reg[0]);
                angle_y_reg <= whole_deg(acc_reg[1]);
                angle_z_reg <= whole_deg(acc_reg[2]);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tilt_x    = tilt_x_reg;
    assign tilt_y    = tilt_y_reg;
    assign fused_x   = fused_x_reg;
    assign fused_y   = fused_y_reg;
    assign accel_z   = accel_z_reg;
    assign angle_x   = angle_x_reg;
    assign angle_y   = angle_y_reg;
    assign angle_z   = angle_z_reg;

endmodule

// ----- hw/rtl/imu_tilt_complementary_fusion_unit.sv -----
// Top level of the IMU tilt fusion unit: configuration registers, front, engine.
//
// Input channel (in_valid/in_ready) takes one raw three-axis sample per request;
// cmd 1 marks a gyro sample, cmd 0 an accelerometer sample.
// Output channel (out_valid/out_ready) returns exactly one result per request, in order.
// A gyro request adds offset-corrected, gain-scaled rates into three Q15.16 angle
// accumulators, with one multiply and one add per axis. An accelerometer request
// runs the shared square-root and CORDIC unit twice and then two blend steps.
// A two-entry queue sits in front of the engine, and a result register sits
// behind it: the input keeps taking requests while a result waits for out_ready,
// until the queue is full; the engine then holds its finished result.
// Configuration (cfg_we/cfg_addr/cfg_wdata) writes one register per cycle and
// must only be used while no request is in flight.
// Reset clears the accumulators, the queue and the output register, and loads
// the register defaults (offsets zero, weight 1311, gain 25614).
module imu_tilt_complementary_fusion_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [23:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic signed [7:0]  tilt_x,
    output logic signed [7:0]  tilt_y,
    output logic signed [15:0] fused_x,
    output logic signed [15:0] fused_y,
    output logic signed [15:0] accel_z,
    output logic signed [15:0] angle_x,
    output logic signed [15:0] angle_y,
    output logic signed [15:0] angle_z
);

`include "imu_tilt_complementary_fusion_unit_assert.svh"

    imu_tcf_pkg::cfg_t           cfg_reg;
    logic                        q_valid;
    logic                        q_pop;
    imu_tcf_pkg::sample_t        q_item;
    imu_tcf_pkg::fifo_status_t   fifo_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x     <= 16'd0;
            cfg_reg.offset_y     <= 16'd0;
            cfg_reg.offset_z     <= 16'd0;
            cfg_reg.blend_weight <= imu_tcf_pkg::BLEND_WEIGHT_RESET;
            cfg_reg.rate_gain    <= imu_tcf_pkg::RATE_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                imu_tcf_pkg::REG_OFFSET_X:     cfg_reg.offset_x     <= cfg_wdata[15:0];
                imu_tcf_pkg::REG_OFFSET_Y:     cfg_reg.offset_y     <= cfg_wdata[15:0];
                imu_tcf_pkg::REG_OFFSET_Z:     cfg_reg.offset_z     <= cfg_wdata[15:0];
                imu_tcf_pkg::REG_BLEND_WEIGHT: cfg_reg.blend_weight <= cfg_wdata[16:0];
                imu_tcf_pkg::REG_RATE_GAIN:    cfg_reg.rate_gain    <= cfg_wdata;
                default:                       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    imu_tcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .raw_x    (raw_x),
        .raw_y    (raw_y),
        .raw_z    (raw_z),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .status   (fifo_status)
    );

    imu_tcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .tilt_x    (tilt_x),
        .tilt_y    (tilt_y),
        .fused_x   (fused_x),
        .fused_y   (fused_y),
        .accel_z   (accel_z),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z)
    );

    `IMU_TCF_ASSERT_IMP(a_gyro_zero, out_valid && kind,
        tilt_x == 8'sd0 && tilt_y == 8'sd0 && fused_x == 16'sd0 && accel_z == 16'sd0)
    `IMU_TCF_ASSERT_IMP(a_tilt_range, out_valid && !kind,
        tilt_x <= 8'sd90 && tilt_x >= -8'sd90 && tilt_y <= 8'sd90 && tilt_y >= -8'sd90)
    `IMU_TCF_ASSERT(a_ready_full, in_ready == (fifo_status.count != imu_tcf_pkg::FIFO_DEPTH))
    `IMU_TCF_ASSERT_IMP(a_pop_needs_item, q_pop, fifo_status.count != 2'd0)

endmodule
